// ===== src/scfr_pkg.sv =====
// Shared types, codes and constants of the serial command frame receiver.
package scfr_pkg;

    // Frame geometry
    localparam int MAX_WORDS  = 32;
    localparam int WIDX_W     = 5;
    localparam int WORDS_W    = 6;
    localparam int ADDR_BYTES = 4;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_WORDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_LIMIT = 2'd1;
    localparam logic [WORDS_W-1:0]   DATA_WORDS_RST = 6'd32;
    localparam logic [31:0]          ADDR_LIMIT_RST = 32'h00FF_E010;

    // Command characters
    localparam logic [7:0] CH_READ    = 8'h52;  // 'R'
    localparam logic [7:0] CH_WRITE   = 8'h57;  // 'W'
    localparam logic [7:0] CH_ERASE   = 8'h58;  // 'X'
    localparam logic [7:0] CH_ACK     = 8'h62;  // 'b'
    localparam logic [7:0] CH_RESEND  = 8'h45;  // 'E'
    localparam logic [7:0] CH_VAL_ON  = 8'h56;  // 'V'
    localparam logic [7:0] CH_VAL_OFF = 8'h76;  // 'v'

    // Result event codes
    typedef enum logic [3:0] {
        EV_STORED  = 4'd0,
        EV_READ    = 4'd1,
        EV_START   = 4'd2,
        EV_ERASE   = 4'd3,
        EV_ACK     = 4'd4,
        EV_RESEND  = 4'd5,
        EV_VAL_ON  = 4'd6,
        EV_VAL_OFF = 4'd7,
        EV_UNKNOWN = 4'd8,
        EV_CKSUM   = 4'd9,
        EV_WORD    = 4'd10,
        EV_LIMIT   = 4'd11
    } event_t;

    typedef enum logic {
        JOB_SIMPLE = 1'b0,
        JOB_BURST  = 1'b1
    } job_kind_t;

    typedef enum logic {
        FR_CMD   = 1'b0,
        FR_FRAME = 1'b1
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_EMIT = 2'd2
    } back_state_t;

    // One unit of work handed from the front end to the back end.
    typedef struct packed {
        job_kind_t           kind;
        event_t              ev;
        logic                val;
        logic [31:0]         faddr;
        logic                wr_hi;
        logic                wr_lo;
        logic [WIDX_W-1:0]   wr_idx;
        logic [7:0]          wr_byte;
        logic [WIDX_W-1:0]   last_idx;
    } job_t;

    // Words per frame, clamped into 1..MAX_WORDS.
    function automatic logic [WORDS_W-1:0] eff_words(input logic [WORDS_W-1:0] dw);
        logic [WORDS_W-1:0] w;
        w = dw;
        if (dw == '0)
        begin
            w = WORDS_W'(1);
        end
        else if (int'(dw) > MAX_WORDS)
        begin
            w = WORDS_W'(MAX_WORDS);
        end
        return w;
    endfunction

endpackage

// ===== src/scfr_front.sv =====
// Front end: decodes commands, tracks the frame and hands jobs to the queue.
module scfr_front
    import scfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    input  logic [WORDS_W-1:0] data_words,
    output logic               push,
    output job_t               job
);

    front_state_t state_reg, state_next;
    logic [6:0]   count_reg, count_next;
    logic [7:0]   sum_reg, sum_next;
    logic [31:0]  addr_reg, addr_next;
    logic         val_reg, val_next;

    logic [WORDS_W-1:0] words;
    logic [7:0]         frame_len;
    logic [7:0]         count_inc;
    logic [7:0]         sum_add;
    logic               frame_end;
    logic [6:0]         data_pos;

    // Frame length and end-of-frame detection
    always_comb
    begin
        words     = eff_words(data_words);
        frame_len = {1'b0, words, 1'b0} + 8'd5;
        count_inc = {1'b0, count_reg} + 8'd1;
        sum_add   = sum_reg + rx_byte;
        frame_end = (count_inc >= frame_len);
        data_pos  = count_reg - 7'(ADDR_BYTES);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            unique case (state_reg)
                FR_CMD:
                begin
                    if (rx_byte == CH_WRITE)
                    begin
                        state_next = FR_FRAME;
                    end
                end
                FR_FRAME:
                begin
                    if (frame_end)
                    begin
                        state_next = FR_CMD;
                    end
                end
                default: state_next = FR_CMD;
            endcase
        end
    end

    // Job formation and frame registers
    always_comb
    begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        addr_next    = addr_reg;
        val_next     = val_reg;
        push         = accept;
        job.kind     = JOB_SIMPLE;
        job.ev       = EV_UNKNOWN;
        job.val      = val_reg;
        job.faddr    = addr_reg;
        job.wr_hi    = 1'b0;
        job.wr_lo    = 1'b0;
        job.wr_idx   = data_pos[WIDX_W:1];
        job.wr_byte  = rx_byte;
        job.last_idx = WIDX_W'(words - WORDS_W'(1));
        if (accept)
        begin
            unique case (state_reg)
                FR_CMD:
                begin
                    unique case (rx_byte)
                        CH_READ:    job.ev = EV_READ;
                        CH_WRITE:
                        begin
                            job.ev     = EV_START;
                            count_next = '0;
                            sum_next   = '0;
                        end
                        CH_ERASE:   job.ev = EV_ERASE;
                        CH_ACK:     job.ev = EV_ACK;
                        CH_RESEND:  job.ev = EV_RESEND;
                        CH_VAL_ON:
                        begin
                            job.ev   = EV_VAL_ON;
                            val_next = 1'b1;
                        end
                        CH_VAL_OFF:
                        begin
                            job.ev   = EV_VAL_OFF;
                            val_next = 1'b0;
                        end
                        default:    job.ev = EV_UNKNOWN;
                    endcase
                    job.val = val_next;
                end
                FR_FRAME:
                begin
                    sum_next = sum_add;
                    if (frame_end)
                    begin
                        count_next = '0;
                        if (sum_add != 8'd0)
                        begin
                            job.ev = EV_CKSUM;
                        end
                        else
                        begin
                            job.kind = JOB_BURST;
                            job.ev   = EV_WORD;
                        end
                    end
                    else
                    begin
                        // Header bytes shift into the address; the rest fill the store.
                        if (count_reg < 7'(ADDR_BYTES))
                        begin
                            addr_next = {addr_reg[23:0], rx_byte};
                        end
                        else
                        begin
                            job.wr_hi = ~data_pos[0];
                            job.wr_lo = data_pos[0];
                        end
                        count_next = count_inc[6:0];
                        job.ev     = EV_STORED;
                        job.faddr  = addr_next;
                    end
                end
                default: job.ev = EV_UNKNOWN;
            endcase
        end
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_CMD;
            count_reg <= '0;
            sum_reg   <= '0;
            addr_reg  <= '0;
            val_reg   <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            addr_reg  <= addr_next;
            val_reg   <= val_next;
        end
    end

endmodule

// ===== src/scfr_queue.sv =====
// Short job queue between the front end and the back end.
module scfr_queue
    import scfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    job_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = q_mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/scfr_back.sv =====
// Back end: word store, burst sequencer and the result output register.
module scfr_back
    import scfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  job_t               head,
    input  logic               empty,
    output logic               pop,
    input  logic [31:0]        addr_limit,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [3:0]         event_res,
    output logic               validation_on,
    output logic [31:0]        frame_address,
    output logic [WIDX_W-1:0]  word_index,
    output logic [31:0]        word_address,
    output logic [15:0]        data_word,
    output logic               last
);

    back_state_t state_reg, state_next;

    logic [7:0]  hi_mem [MAX_WORDS];
    logic [7:0]  lo_mem [MAX_WORDS];
    logic [15:0] rd_data_reg;

    logic [WIDX_W-1:0] idx_reg, idx_next;
    logic [WIDX_W-1:0] last_idx_reg, last_idx_next;
    logic [31:0]       wa_reg, wa_next;
    logic [31:0]       baddr_reg, baddr_next;
    logic              bval_reg, bval_next;

    logic              out_valid_reg;
    event_t            ev_reg, ev_next;
    logic              val_out_reg, val_out_next;
    logic [31:0]       faddr_reg, faddr_next;
    logic [WIDX_W-1:0] widx_reg, widx_next;
    logic [31:0]       waddr_reg, waddr_next;
    logic [15:0]       data_reg, data_next;
    logic              last_reg, last_next;

    logic out_free;
    logic load;
    logic limit_hit;
    logic emit_last;
    logic store_wr;

    assign out_free  = ~out_valid_reg | ~out_stall;
    assign limit_hit = (wa_reg >= addr_limit);
    assign emit_last = limit_hit | (idx_reg == last_idx_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty && out_free && head.kind == JOB_BURST)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ: state_next = BK_EMIT;
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? BK_IDLE : BK_READ;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Control and result payload
    always_comb
    begin
        pop           = 1'b0;
        load          = 1'b0;
        store_wr      = 1'b0;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        wa_next       = wa_reg;
        baddr_next    = baddr_reg;
        bval_next     = bval_reg;
        ev_next       = ev_reg;
        val_out_next  = val_out_reg;
        faddr_next    = faddr_reg;
        widx_next     = widx_reg;
        waddr_next    = waddr_reg;
        data_next     = data_reg;
        last_next     = last_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty && out_free)
                begin
                    pop = 1'b1;
                    if (head.kind == JOB_SIMPLE)
                    begin
                        load         = 1'b1;
                        store_wr     = 1'b1;
                        ev_next      = head.ev;
                        val_out_next = head.val;
                        faddr_next   = head.faddr;
                        widx_next    = '0;
                        waddr_next   = '0;
                        data_next    = '0;
                        last_next    = 1'b1;
                    end
                    else
                    begin
                        idx_next      = '0;
                        last_idx_next = head.last_idx;
                        wa_next       = {1'b0, head.faddr[31:1]};
                        baddr_next    = head.faddr;
                        bval_next     = head.val;
                    end
                end
            end
            BK_READ:
            begin
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    load         = 1'b1;
                    ev_next      = limit_hit ? EV_LIMIT : EV_WORD;
                    val_out_next = bval_reg;
                    faddr_next   = baddr_reg;
                    widx_next    = idx_reg;
                    waddr_next   = wa_reg;
                    data_next    = limit_hit ? 16'd0 : rd_data_reg;
                    last_next    = emit_last;
                    idx_next     = idx_reg + WIDX_W'(1);
                    wa_next      = wa_reg + 32'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Burst and result payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        wa_reg       <= wa_next;
        baddr_reg    <= baddr_next;
        bval_reg     <= bval_next;
        ev_reg       <= ev_next;
        val_out_reg  <= val_out_next;
        faddr_reg    <= faddr_next;
        widx_reg     <= widx_next;
        waddr_reg    <= waddr_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
    end

    // Word store: byte-lane writes from stored bytes, registered read for bursts
    always_ff @(posedge clk)
    begin
        if (store_wr && head.wr_hi)
        begin
            hi_mem[head.wr_idx] <= head.wr_byte;
        end
        if (store_wr && head.wr_lo)
        begin
            lo_mem[head.wr_idx] <= head.wr_byte;
        end
        rd_data_reg <= {hi_mem[idx_reg], lo_mem[idx_reg]};
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = ev_reg;
    assign validation_on = val_out_reg;
    assign frame_address = faddr_reg;
    assign word_index    = widx_reg;
    assign word_address  = waddr_reg;
    assign data_word     = data_reg;
    assign last          = last_reg;

endmodule

// ===== src/serial_command_frame_receiver.sv =====
// Top level of the serial command frame receiver: configuration, wiring and checks.
//
//  Channel   Direction  Handshake              Payload
//  input     in         in_valid / in_stall    rx_byte
//  output    out        out_valid / out_stall  event_res, validation_on, frame_address,
//                                              word_index, word_address, data_word, last
//  config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A byte giving one result goes through the job queue, then the output register,
// and such bytes can follow each other every cycle through the four-entry job queue
// while out_stall is low. Each frame word passes BK_READ (store read) and BK_EMIT.
// Reset clears all control state; the word store is not cleared and needs no pass.
// in_stall rises only while the job queue is full; out_stall holds the output register.
module serial_command_frame_receiver
    import scfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [3:0]           event_res,
    output logic                 validation_on,
    output logic [31:0]          frame_address,
    output logic [WIDX_W-1:0]    word_index,
    output logic [31:0]          word_address,
    output logic [15:0]          data_word,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic [WORDS_W-1:0] data_words_reg;
    logic [31:0]        addr_limit_reg;

    logic accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    job_t push_job;
    job_t head_job;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_words_reg <= DATA_WORDS_RST;
            addr_limit_reg <= ADDR_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_DATA_WORDS)
            begin
                data_words_reg <= cfg_data[WORDS_W-1:0];
            end
            else if (cfg_index == CFG_ADDR_LIMIT)
            begin
                addr_limit_reg <= cfg_data;
            end
        end
    end

    // Input transfer
    assign in_stall = q_full;
    assign accept   = in_valid & ~in_stall;

    scfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .data_words (data_words_reg),
        .push       (push),
        .job        (push_job)
    );

    scfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    scfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head_job),
        .empty         (q_empty),
        .pop           (pop),
        .addr_limit    (addr_limit_reg),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .event_res     (event_res),
        .validation_on (validation_on),
        .frame_address (frame_address),
        .word_index    (word_index),
        .word_address  (word_address),
        .data_word     (data_word),
        .last          (last)
    );

`ifndef SYNTHESIS
    // Every result other than a frame word closes the results of its byte.
    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res != EV_WORD) |-> last)
        else $error("non-word result without last");

    // Only frame words and limit results carry a word index or word address.
    a_index_only_words: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (word_index != '0 || word_address != '0))
            |-> (event_res == EV_WORD || event_res == EV_LIMIT))
        else $error("word fields set on a non-word result");

    // Validation commands show their new flag.
    a_val_on: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_VAL_ON) |-> validation_on)
        else $error("validation on not reflected");

    a_val_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_VAL_OFF) |-> !validation_on)
        else $error("validation off not reflected");
`endif

endmodule
